// ----- src/pc_scancode_decoder_fifo_macros.svh -----
// Assertion macros shared by the scancode decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PC_SCANCODE_DECODER_FIFO_MACROS_SVH
`define PC_SCANCODE_DECODER_FIFO_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PCSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define PCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- src/pcsd_pkg.sv -----
// Package for the PC scancode decoder: item types, command codes and scancode constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pcsd_pkg;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_DRAIN = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic [7:0] SC_EXTEND       = 8'hE0;
    localparam logic [7:0] SC_PAUSE_PREFIX = 8'hE1;
    localparam logic [7:0] SC_PAUSE_MAKE   = 8'h1D;
    localparam logic [7:0] SC_PAUSE_BREAK  = 8'h9D;
    localparam logic [7:0] PAUSE_CODE_RST  = 8'd97;
    localparam logic [1:0] PAUSE_LEN       = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] scan_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] key_code;
        logic       pressed;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
        logic       press;
    } t_key_event;

    typedef struct packed {
        logic push;
        logic drain;
        logic flush;
    } t_ring_cmd;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } t_drain_state;

endpackage

// ----- src/pcsd_decode.sv -----
// Set-1 scancode byte decoder holding the extended flag and the Pause countdown.
// Depends on pcsd_pkg.
`timescale 1ns / 1ps

module pcsd_decode
    import pcsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pause_code,
    output t_key_event o_event
);

    logic       r_ext;
    logic       n_ext;
    logic [1:0] r_cd;
    logic [1:0] n_cd;

    always_comb begin
        n_ext         = r_ext;
        n_cd          = r_cd;
        o_event.valid = 1'b0;
        o_event.code  = {r_ext, i_byte[6:0]};
        o_event.press = ~i_byte[7];
        priority if (i_byte == SC_EXTEND) begin
            n_ext = 1'b1;
        end else if (r_cd != 2'd0) begin
            n_cd = r_cd - 2'd1;
            if (i_byte == SC_PAUSE_MAKE || i_byte == SC_PAUSE_BREAK) begin
                o_event.valid = 1'b1;
                o_event.code  = i_pause_code;
                o_event.press = (i_byte == SC_PAUSE_MAKE);
                n_ext         = 1'b0;
            end
        end else if (i_byte == SC_PAUSE_PREFIX) begin
            n_cd = PAUSE_LEN;
        end else begin
            o_event.valid = 1'b1;
            n_ext         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext <= 1'b0;
            r_cd  <= 2'd0;
        end else if (i_take) begin
            r_ext <= n_ext;
            r_cd  <= n_cd;
        end
    end

endmodule

// ----- src/pcsd_ring.sv -----
// Key event ring: one synchronous memory, read and write pointers and the drain sequencer.
// Depends on pcsd_pkg and pc_scancode_decoder_fifo_macros.svh.
`timescale 1ns / 1ps

module pcsd_ring
    import pcsd_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ring_cmd  i_cmd,
    input  logic [7:0] i_code,
    input  logic       i_press,
    output logic       o_busy,
    output logic       o_strobe,
    output t_out_item  o_result
);

`include "pc_scancode_decoder_fifo_macros.svh"

    localparam int PW = $clog2(DEPTH);

    logic [8:0]    r_mem [DEPTH];
    logic [8:0]    r_rdata;
    logic [PW-1:0] r_rd;
    logic [PW-1:0] n_rd;
    logic [PW-1:0] r_wr;
    logic [PW-1:0] n_wr;
    t_drain_state  r_state;
    t_drain_state  n_state;
    logic          r_strobe;
    logic          n_strobe;
    logic          r_last;
    logic          n_last;
    logic [PW-1:0] rd_nxt;
    logic [PW-1:0] wr_nxt;
    logic          full;
    logic          wr_en;
    logic          rd_en;

    assign rd_nxt = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign wr_nxt = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign full   = (wr_nxt == r_rd);
    assign wr_en  = i_cmd.push && !full && (r_state == ST_IDLE);
    assign rd_en  = (r_state == ST_DRAIN);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= {i_code, i_press};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[r_rd];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_strobe = 1'b0;
        n_last   = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.flush) begin
                    n_rd = '0;
                    n_wr = '0;
                end else if (wr_en) begin
                    n_wr = wr_nxt;
                end else if (i_cmd.drain && (r_rd != r_wr)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_rd     = rd_nxt;
                n_strobe = 1'b1;
                n_last   = (rd_nxt == r_wr);
                if (rd_nxt == r_wr) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd     <= '0;
            r_wr     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd     <= n_rd;
            r_wr     <= n_wr;
            r_strobe <= n_strobe;
        end
        r_last <= n_last;
    end

    assign o_busy            = (r_state == ST_DRAIN);
    assign o_strobe          = r_strobe;
    assign o_result.key_code = r_rdata[8:1];
    assign o_result.pressed  = r_rdata[0];
    assign o_result.last     = r_last;

    `PCSD_ASSERT_IMPL(a_no_rw_overlap, i_clk, i_rst_n, rd_en, !wr_en)
    `PCSD_ASSERT_NEXT(a_strobe_follows_read, i_clk, i_rst_n, rd_en, r_strobe)
    `PCSD_ASSERT_IMPL(a_drain_not_empty, i_clk, i_rst_n, rd_en, r_rd != r_wr)
    `PCSD_ASSERT_IMPL(a_last_leaves_empty, i_clk, i_rst_n, r_strobe && r_last, r_rd == r_wr)

endmodule

// ----- src/pc_scancode_decoder_fifo.sv -----
// Top level of the PC set-1 scancode decoder with its key event ring.
// Depends on pcsd_pkg, pcsd_decode and pcsd_ring.
//
//   Channel   Ports                   Handshake
//   input     start, busy, i_item     taken when start is high and busy is low
//   result    o_strobe, o_result      valid for one cycle while o_strobe is high
//   config    i_cfg_we, i_cfg_wdata   pause_code written when i_cfg_we is high
//
// A scancode byte or a flush item never raises busy.
// A drain of n queued events holds busy high while they are read out, and the
// events appear one per cycle, paced by the single read port of the event memory.
// Reset is synchronous and needs no clearing pass; the memory is not cleared.
// The receiver cannot stall, so a drain always runs at one event per cycle.
`timescale 1ns / 1ps

module pc_scancode_decoder_fifo
    import pcsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_item   i_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_strobe,
    output t_out_item  o_result
);

    logic [7:0] r_pause_code;
    logic       accept;
    logic       take_byte;
    t_key_event key_event;
    t_ring_cmd  ring_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_code <= PAUSE_CODE_RST;
        end else if (i_cfg_we) begin
            r_pause_code <= i_cfg_wdata;
        end
    end

    assign accept         = start && !busy;
    assign take_byte      = accept && (i_item.mode == MODE_BYTE);
    assign ring_cmd.push  = take_byte && key_event.valid;
    assign ring_cmd.drain = accept && (i_item.mode == MODE_DRAIN);
    assign ring_cmd.flush = accept && (i_item.mode == MODE_FLUSH);

    pcsd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take_byte),
        .i_byte       (i_item.scan_byte),
        .i_pause_code (r_pause_code),
        .o_event      (key_event)
    );

    pcsd_ring #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ring_cmd),
        .i_code   (key_event.code),
        .i_press  (key_event.press),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ----- dv/pcsd_key_event_checker.sv -----
// Key event checker for the scancode decoder: keeps its own copy of the decode state and
// the event ring, predicts every drained event and compares it with the result port.
// Depends on pcsd_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module pcsd_key_event_checker
    import pcsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  t_in_item   i_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_strobe,
    input  t_out_item  i_result,
    output int         o_pending,
    output int         o_errors
);

    localparam int RING_SLOTS = 32;

    t_out_item  queued_events[$];
    logic [7:0] code_mem [RING_SLOTS];
    logic       press_mem [RING_SLOTS];
    logic [4:0] rd_ptr;
    logic [4:0] wr_ptr;
    logic       ext_flag;
    logic [1:0] pause_left;
    logic [7:0] pause_code;
    int         errors;

    task automatic store_key_event(input logic [7:0] code, input logic press);
        logic [4:0] nxt;
        nxt = wr_ptr + 5'd1;
        if (nxt != rd_ptr) begin
            code_mem[wr_ptr]  = code;
            press_mem[wr_ptr] = press;
            wr_ptr = nxt;
        end
    endtask

    task automatic decode_scan_byte(input logic [7:0] b);
        if (b == SC_EXTEND) begin
            ext_flag = 1'b1;
        end else if (pause_left != 2'd0) begin
            pause_left = pause_left - 2'd1;
            if (b == SC_PAUSE_MAKE || b == SC_PAUSE_BREAK) begin
                ext_flag = 1'b0;
                store_key_event(pause_code, b == SC_PAUSE_MAKE);
            end
        end else if (b == SC_PAUSE_PREFIX) begin
            pause_left = PAUSE_LEN;
        end else begin
            store_key_event({ext_flag, b[6:0]}, ~b[7]);
            ext_flag = 1'b0;
        end
    endtask

    task automatic drain_key_events();
        t_out_item ev;
        while (rd_ptr != wr_ptr) begin
            ev.key_code = code_mem[rd_ptr];
            ev.pressed  = press_mem[rd_ptr];
            rd_ptr = rd_ptr + 5'd1;
            ev.last = (rd_ptr == wr_ptr);
            queued_events.push_back(ev);
        end
    endtask

    task automatic compare_key_event(input t_out_item got);
        t_out_item want;
        if (queued_events.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected key event: key_code=%h pressed=%b last=%b",
                         got.key_code, got.pressed, got.last);
            end
        end else begin
            want = queued_events.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("key event mismatch: expected key_code=%h pressed=%b last=%b",
                             want.key_code, want.pressed, want.last,
                             ", got key_code=%h pressed=%b last=%b",
                             got.key_code, got.pressed, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ext_flag   = 1'b0;
            pause_left = 2'd0;
            rd_ptr     = 5'd0;
            wr_ptr     = 5'd0;
            pause_code = PAUSE_CODE_RST;
            queued_events.delete();
        end else begin
            if (i_strobe) begin
                compare_key_event(i_result);
            end
            if (i_cfg_we) begin
                pause_code = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                case (i_item.mode)
                    MODE_BYTE: begin
                        decode_scan_byte(i_item.scan_byte);
                    end
                    MODE_DRAIN: begin
                        drain_key_events();
                    end
                    MODE_FLUSH: begin
                        rd_ptr = 5'd0;
                        wr_ptr = 5'd0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= queued_events.size();
        o_errors  <= errors;
    end

endmodule

// ----- dv/tb_top.sv -----
// Top of the scancode decoder testbench: clock, reset, directed and random scancode items
// with random gaps, pause_code writes between phases, and the final verdict.
// Depends on pcsd_pkg, pc_scancode_decoder_fifo and pcsd_key_event_checker.
`timescale 1ns / 1ps

module tb_top;
    import pcsd_pkg::*;

    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         ITEMS_PER_PHASE = 5;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    t_in_item   i_item      = '0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;
    logic       busy;
    logic       o_strobe;
    t_out_item  o_result;
    int         pending;
    int         mismatches;
    int         items_sent;
    int         cycles;
    bit         steady;

    pc_scancode_decoder_fifo u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    pcsd_key_event_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .o_pending   (pending),
        .o_errors    (mismatches)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pc_scancode_decoder_fifo: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
        int pick;
        int gap;
        i_item <= '{mode, b};
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        items_sent++;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60) begin
            gap = 0;
        end else if (pick < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_pause_code(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_key_sequence();
        int         pick;
        logic [7:0] tail;
        logic [7:0] pause_byte;
        pick       = $urandom_range(0, 99);
        tail       = 8'($urandom_range(0, 255));
        pause_byte = $urandom_range(0, 1) ? SC_PAUSE_MAKE : SC_PAUSE_BREAK;
        if (pick < 55) begin
            send_item(MODE_BYTE, tail);
        end else if (pick < 75) begin
            send_item(MODE_BYTE, SC_EXTEND);
            send_item(MODE_BYTE, tail);
        end else if (pick < 90) begin
            send_item(MODE_BYTE, SC_PAUSE_PREFIX);
            if ($urandom_range(0, 1)) begin
                send_item(MODE_BYTE, pause_byte);
                send_item(MODE_BYTE, tail);
            end else begin
                send_item(MODE_BYTE, tail);
                send_item(MODE_BYTE, pause_byte);
            end
        end else begin
            send_item(MODE_BYTE, $urandom_range(0, 1) ? SC_EXTEND : SC_PAUSE_PREFIX);
        end
    endtask

    task automatic run_random_phase(input int quota);
        int stop_at;
        int pick;
        int burst;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            steady = ($urandom_range(0, 3) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 4) begin
                send_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
            end else if (pick < 7) begin
                send_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
            end else if (pick < 10) begin
                wait_for_quiet();
            end else begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(34, 40)
                                                    : $urandom_range(0, 6);
                repeat (burst) send_key_sequence();
                send_item(MODE_DRAIN, 8'($urandom_range(0, 255)));
            end
        end
        steady = 1'b0;
        send_item(MODE_DRAIN, 8'h00);
        wait_for_quiet();
    endtask

    task automatic fill_ring(input int count);
        logic [7:0] b;
        repeat (count) begin
            b = 8'($urandom_range(0, 255));
            if (b == SC_EXTEND || b == SC_PAUSE_PREFIX) begin
                b = b ^ 8'h10;
            end
            send_item(MODE_BYTE, b);
        end
        send_item(MODE_DRAIN, 8'h00);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'h7F);
        send_item(MODE_BYTE, 8'h80);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_DRAIN, 8'h00);
        send_item(MODE_BYTE, SC_EXTEND);
        send_item(MODE_BYTE, 8'h1C);
        send_item(MODE_BYTE, SC_EXTEND);
        send_item(MODE_BYTE, 8'h9C);
        send_item(MODE_BYTE, SC_PAUSE_PREFIX);
        send_item(MODE_BYTE, SC_PAUSE_MAKE);
        send_item(MODE_BYTE, 8'h45);
        send_item(MODE_DRAIN, 8'hFF);
        send_item(MODE_BYTE, SC_PAUSE_PREFIX);
        send_item(MODE_BYTE, SC_EXTEND);
        send_item(MODE_BYTE, 8'h2A);
        send_item(MODE_BYTE, SC_PAUSE_BREAK);
        send_item(MODE_BYTE, SC_EXTEND);
        send_item(MODE_BYTE, 8'h3B);
        send_item(MODE_DRAIN, 8'h00);
        send_item(MODE_DRAIN, 8'h00);
        send_item(MODE_UNUSED, 8'hFF);
        send_item(MODE_BYTE, 8'h11);
        send_item(MODE_FLUSH, 8'h00);
        send_item(MODE_DRAIN, 8'h00);
        wait_for_quiet();

        run_random_phase(ITEMS_PER_PHASE);
        write_pause_code(8'hFF);
        run_random_phase(ITEMS_PER_PHASE);
        write_pause_code(8'h00);
        fill_ring(34);
        run_random_phase(ITEMS_PER_PHASE);
        write_pause_code(8'($urandom_range(1, 254)));
        run_random_phase(ITEMS_PER_PHASE);

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("pc_scancode_decoder_fifo: match");
        end else begin
            $display("pc_scancode_decoder_fifo: mismatch");
        end
        $finish;
    end

endmodule
